FILE: hw/rtl/gdt_pkg.sv
// ----------------------------------------------------------------------------
// gdt_pkg: shared types and constants of the gateway discovery table
// Field types, status and request codes, the table entry layout, the
// controller states and the byte step of the MAC key CRC.
// ----------------------------------------------------------------------------
package gdt_pkg;

   typedef logic [47:0] mac_type;
   typedef logic [31:0] ip_type;
   typedef logic [31:0] key_type;
   typedef logic [7:0]  life_type;
   typedef logic [7:0]  byte_type;
   typedef logic [5:0]  index_type;
   typedef logic [6:0]  count_type;
   typedef logic [2:0]  byte_count_type;

   typedef enum logic [2:0] {
      STATUS_NONE      = 3'd0,
      STATUS_LEARNED   = 3'd1,
      STATUS_COMMITTED = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_TICK      = 3'd4
   } status_type;

   typedef enum logic {
      REQ_PACKET = 1'b0,
      REQ_TICK   = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_LEARN,
      OP_COMMIT,
      OP_IGNORE
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic     valid;
      key_type  key;
      logic     committed;
      mac_type  gateway_mac;
      mac_type  client_mac;
      ip_type   client_ip;
      life_type lifetime;
   } entry_type;

   localparam key_type        CRC_POLY       = 32'hEDB88320;
   localparam key_type        CRC_INIT       = 32'hFFFFFFFF;
   localparam byte_count_type LAST_BYTE      = 3'd5;
   localparam life_type       LIFETIME_RESET = 8'd60;

   // Reflected CRC-32, one message byte.
   function automatic key_type crc_byte(key_type crc, byte_type data);
      key_type c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

FILE: hw/rtl/gdt_channels.sv
// ----------------------------------------------------------------------------
// gdt_channels: valid/ready channels of the gateway discovery table
// Request, response and register-write channels, each with source and
// sink views.
// ----------------------------------------------------------------------------
interface gdt_req_if;
   logic             valid;
   logic             ready;
   logic             req_type;
   logic             discovery_on;
   logic             from_client_link;
   gdt_pkg::mac_type dst_mac;
   gdt_pkg::mac_type src_mac;
   gdt_pkg::ip_type  src_ip;
   gdt_pkg::ip_type  dst_ip;

   modport source (
      output valid, req_type, discovery_on, from_client_link,
             dst_mac, src_mac, src_ip, dst_ip,
      input  ready
   );
   modport sink (
      input  valid, req_type, discovery_on, from_client_link,
             dst_mac, src_mac, src_ip, dst_ip,
      output ready
   );
endinterface

interface gdt_rsp_if;
   logic                  valid;
   logic                  ready;
   gdt_pkg::status_type   status;
   gdt_pkg::index_type    entry_index;
   gdt_pkg::count_type    expired_count;

   modport source (
      output valid, status, entry_index, expired_count,
      input  ready
   );
   modport sink (
      input  valid, status, entry_index, expired_count,
      output ready
   );
endinterface

interface gdt_csr_if;
   logic              valid;
   logic              ready;
   gdt_pkg::life_type data;

   modport source (
      output valid, data,
      input  ready
   );
   modport sink (
      input  valid, data,
      output ready
   );
endinterface

FILE: hw/rtl/gateway_discovery_table.sv
// ----------------------------------------------------------------------------
// gateway_discovery_table: learns gateway candidates from sniffed headers
// Request channel req_channel takes packet headers and ageing ticks, one
// transfer per item; each item yields one transfer on rsp_channel with a
// status, the slot touched and, for ticks, the number of entries freed.
// csr_channel writes the lifetime given to new entries (reset 60) and is always ready; write
// it only while no item is in flight.
// Timing: the table lives in one memory with a registered read. Every tick
// and every packet with discovery on walks all TABLE_ENTRIES slots, one
// read per cycle, so the memory read port sets the rate. A packet first
// hashes the six bytes of its MAC key, a byte per cycle, then walks; a
// packet with discovery off goes straight to its result. One item is worked at a
// time; the next is accepted as soon as the previous result sits in the
// output register, even if the receiver has not taken it.
// Reset: a clearing pass marks every slot free; req_channel.ready stays
// low until it ends.
// Stall: a result waits in the output register while rsp_channel.ready is
// low; a finished item holds in ST_FINISH until the register frees up.
// ----------------------------------------------------------------------------
module gateway_discovery_table #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic      clock,
   input  logic      reset,
   gdt_req_if.sink   req_channel,
   gdt_rsp_if.source rsp_channel,
   gdt_csr_if.sink   csr_channel
);

   localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] ALL_SLOTS = CNT_W'(TABLE_ENTRIES);
   localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(TABLE_ENTRIES - 1);

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   gdt_pkg::state_type      state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;         // slot walk / clear counter
   logic                    pend_ff, pend_in;       // read data arrives this cycle
   logic [ADDR_W-1:0]       pidx_ff, pidx_in;       // slot of arriving read data
   gdt_pkg::op_type         op_ff, op_in;
   gdt_pkg::mac_type        dst_mac_ff, dst_mac_in;
   gdt_pkg::mac_type        src_mac_ff, src_mac_in;
   gdt_pkg::ip_type         src_ip_ff, src_ip_in;
   gdt_pkg::ip_type         dst_ip_ff, dst_ip_in;
   gdt_pkg::mac_type        shift_ff, shift_in;     // MAC bytes left to hash
   gdt_pkg::key_type        crc_ff, crc_in;
   gdt_pkg::byte_count_type byte_ff, byte_in;
   logic                    match_ff, match_in;
   logic [ADDR_W-1:0]       match_idx_ff, match_idx_in;
   gdt_pkg::entry_type      match_row_ff, match_row_in;
   logic                    free_ff, free_in;
   logic [ADDR_W-1:0]       free_idx_ff, free_idx_in;
   logic [CNT_W-1:0]        expired_ff, expired_in;
   gdt_pkg::life_type       lifetime_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   gdt_pkg::status_type     rsp_status_ff, rsp_status_in;
   gdt_pkg::index_type      rsp_index_ff, rsp_index_in;
   gdt_pkg::count_type      rsp_expired_ff, rsp_expired_in;
   gdt_pkg::entry_type      rd_row_ff;

   // ---------------------------------------------------------------
   // Control
   // ---------------------------------------------------------------
   logic                    req_ready;
   logic                    req_fire;
   logic                    rsp_load;
   logic                    rd_en;
   logic [ADDR_W-1:0]       rd_addr;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   gdt_pkg::entry_type      wr_row;
   gdt_pkg::key_type        key;
   logic                    walk_done;
   logic                    commit_ok;

   gdt_pkg::entry_type      entry_mem [TABLE_ENTRIES];

   assign req_ready = (state_ff == gdt_pkg::ST_IDLE);
   assign req_fire  = req_channel.valid && req_ready;
   assign key       = ~crc_ff;
   assign walk_done = (cnt_ff == ALL_SLOTS) && !pend_ff;
   assign rd_addr   = cnt_ff[ADDR_W-1:0];
   assign rsp_load  = (state_ff == gdt_pkg::ST_FINISH) &&
                      (!rsp_valid_ff || rsp_channel.ready);

   // Commit needs an uncommitted pretender whose addresses all agree.
   assign commit_ok = match_ff && !match_row_ff.committed &&
                      (match_row_ff.client_ip == dst_ip_ff) &&
                      (match_row_ff.client_mac == dst_mac_ff) &&
                      (match_row_ff.gateway_mac == src_mac_ff);

   // ---------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gdt_pkg::ST_CLEAR: begin
            if (cnt_ff == LAST_SLOT) state_in = gdt_pkg::ST_IDLE;
         end
         gdt_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_channel.req_type == gdt_pkg::REQ_TICK) begin
                  state_in = gdt_pkg::ST_WALK;
               end else if (!req_channel.discovery_on) begin
                  state_in = gdt_pkg::ST_FINISH;
               end else begin
                  state_in = gdt_pkg::ST_HASH;
               end
            end
         end
         gdt_pkg::ST_HASH: begin
            if (byte_ff == gdt_pkg::LAST_BYTE) state_in = gdt_pkg::ST_WALK;
         end
         gdt_pkg::ST_WALK: begin
            if (walk_done) state_in = gdt_pkg::ST_FINISH;
         end
         gdt_pkg::ST_FINISH: begin
            if (rsp_load) state_in = gdt_pkg::ST_IDLE;
         end
         default: state_in = gdt_pkg::ST_CLEAR;
      endcase
   end

   // ---------------------------------------------------------------
   // Datapath and memory control
   // ---------------------------------------------------------------
   always_comb begin
      cnt_in         = cnt_ff;
      pend_in        = 1'b0;
      pidx_in        = pidx_ff;
      op_in          = op_ff;
      dst_mac_in     = dst_mac_ff;
      src_mac_in     = src_mac_ff;
      src_ip_in      = src_ip_ff;
      dst_ip_in      = dst_ip_ff;
      shift_in       = shift_ff;
      crc_in         = crc_ff;
      byte_in        = byte_ff;
      match_in       = match_ff;
      match_idx_in   = match_idx_ff;
      match_row_in   = match_row_ff;
      free_in        = free_ff;
      free_idx_in    = free_idx_ff;
      expired_in     = expired_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_expired_in = rsp_expired_ff;
      rd_en          = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = pidx_ff;
      wr_row         = rd_row_ff;

      unique case (state_ff)
         gdt_pkg::ST_CLEAR: begin
            // Sweep the table once, marking every slot free.
            wr_en   = 1'b1;
            wr_addr = cnt_ff[ADDR_W-1:0];
            wr_row  = '0;
            cnt_in  = (cnt_ff == LAST_SLOT) ? '0 : cnt_ff + CNT_W'(1);
         end

         gdt_pkg::ST_IDLE: begin
            if (req_fire) begin
               dst_mac_in  = req_channel.dst_mac;
               src_mac_in  = req_channel.src_mac;
               src_ip_in   = req_channel.src_ip;
               dst_ip_in   = req_channel.dst_ip;
               shift_in    = req_channel.from_client_link ? req_channel.dst_mac
                                                          : req_channel.src_mac;
               crc_in      = gdt_pkg::CRC_INIT;
               byte_in     = '0;
               cnt_in      = '0;
               match_in    = 1'b0;
               free_in     = 1'b0;
               expired_in  = '0;
               if (req_channel.req_type == gdt_pkg::REQ_TICK) begin
                  op_in = gdt_pkg::OP_TICK;
               end else if (!req_channel.discovery_on) begin
                  op_in = gdt_pkg::OP_IGNORE;
               end else if (req_channel.from_client_link) begin
                  op_in = gdt_pkg::OP_LEARN;
               end else begin
                  op_in = gdt_pkg::OP_COMMIT;
               end
            end
         end

         gdt_pkg::ST_HASH: begin
            // Hash the MAC first byte first, one byte per cycle.
            crc_in   = gdt_pkg::crc_byte(crc_ff, shift_ff[47:40]);
            shift_in = shift_ff << 8;
            byte_in  = byte_ff + 3'd1;
         end

         gdt_pkg::ST_WALK: begin
            // Issue the read of the next slot.
            if (cnt_ff != ALL_SLOTS) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               pidx_in = cnt_ff[ADDR_W-1:0];
               cnt_in  = cnt_ff + CNT_W'(1);
            end
            // Examine the slot read last cycle.
            if (pend_ff) begin
               if (op_ff == gdt_pkg::OP_TICK) begin
                  wr_en   = 1'b1;
                  wr_addr = pidx_ff;
                  wr_row  = rd_row_ff;
                  if (rd_row_ff.valid) begin
                     if (rd_row_ff.lifetime != '0) begin
                        wr_row.lifetime = rd_row_ff.lifetime - 8'd1;
                     end
                     if (wr_row.lifetime == '0) begin
                        wr_row.valid = 1'b0;
                        expired_in   = expired_ff + CNT_W'(1);
                     end
                  end
               end else begin
                  // Keep the lowest matching slot and the lowest free one.
                  if (rd_row_ff.valid && (rd_row_ff.key == key) && !match_ff) begin
                     match_in     = 1'b1;
                     match_idx_in = pidx_ff;
                     match_row_in = rd_row_ff;
                  end
                  if (!rd_row_ff.valid && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = pidx_ff;
                  end
               end
            end
         end

         gdt_pkg::ST_FINISH: begin
            rsp_status_in  = gdt_pkg::STATUS_NONE;
            rsp_index_in   = '0;
            rsp_expired_in = '0;
            case (op_ff)
               gdt_pkg::OP_TICK: begin
                  rsp_status_in  = gdt_pkg::STATUS_TICK;
                  rsp_expired_in = gdt_pkg::count_type'(expired_ff);
               end
               gdt_pkg::OP_LEARN: begin
                  if (!match_ff) begin
                     if (free_ff) begin
                        wr_en              = rsp_load;
                        wr_addr            = free_idx_ff;
                        wr_row.valid       = 1'b1;
                        wr_row.key         = key;
                        wr_row.committed   = 1'b0;
                        wr_row.gateway_mac = dst_mac_ff;
                        wr_row.client_mac  = src_mac_ff;
                        wr_row.client_ip   = src_ip_ff;
                        wr_row.lifetime    = lifetime_ff;
                        rsp_status_in      = gdt_pkg::STATUS_LEARNED;
                        rsp_index_in       = gdt_pkg::index_type'(free_idx_ff);
                     end else begin
                        rsp_status_in = gdt_pkg::STATUS_FULL;
                     end
                  end
               end
               gdt_pkg::OP_COMMIT: begin
                  if (commit_ok) begin
                     wr_en            = rsp_load;
                     wr_addr          = match_idx_ff;
                     wr_row           = match_row_ff;
                     wr_row.committed = 1'b1;
                     rsp_status_in    = gdt_pkg::STATUS_COMMITTED;
                     rsp_index_in     = gdt_pkg::index_type'(match_idx_ff);
                  end
               end
               default: begin
                  rsp_status_in = gdt_pkg::STATUS_NONE;
               end
            endcase
            // Hold the old result until the output register frees up.
            if (!rsp_load) begin
               rsp_status_in  = rsp_status_ff;
               rsp_index_in   = rsp_index_ff;
               rsp_expired_in = rsp_expired_ff;
            end
         end

         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_channel.ready);

   // ---------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gdt_pkg::ST_CLEAR;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lifetime_ff  <= gdt_pkg::LIFETIME_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_channel.valid) lifetime_ff <= csr_channel.data;
      end
   end

   // ---------------------------------------------------------------
   // Payload registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      pidx_ff        <= pidx_in;
      op_ff          <= op_in;
      dst_mac_ff     <= dst_mac_in;
      src_mac_ff     <= src_mac_in;
      src_ip_ff      <= src_ip_in;
      dst_ip_ff      <= dst_ip_in;
      shift_ff       <= shift_in;
      crc_ff         <= crc_in;
      byte_ff        <= byte_in;
      match_ff       <= match_in;
      match_idx_ff   <= match_idx_in;
      match_row_ff   <= match_row_in;
      free_ff        <= free_in;
      free_idx_ff    <= free_idx_in;
      expired_ff     <= expired_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_expired_ff <= rsp_expired_in;
   end

   // ---------------------------------------------------------------
   // Entry memory: one write port, one registered read port
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (wr_en) entry_mem[wr_addr] <= wr_row;
      if (rd_en) rd_row_ff <= entry_mem[rd_addr];
   end

   // ---------------------------------------------------------------
   // Ports
   // ---------------------------------------------------------------
   assign req_channel.ready         = req_ready;
   assign csr_channel.ready         = 1'b1;
   assign rsp_channel.valid         = rsp_valid_ff;
   assign rsp_channel.status        = rsp_status_ff;
   assign rsp_channel.entry_index   = rsp_index_ff;
   assign rsp_channel.expired_count = rsp_expired_ff;

endmodule

FILE: tb/sv/gateway_discovery_table_tb.sv
// ----------------------------------------------------------------------------
// gateway_discovery_table_tb: self-checking bench of the gateway discovery table
// Drives packet headers and ageing ticks through the request channel, keeps
// a shadow table that learns, commits and ages entries the same way, and
// checks every response against it. A short directed pass hits the corner
// cases; random traffic of learn/commit sequences, broken commits, key
// collisions, ticks and noise follows under several lifetime settings.
// ----------------------------------------------------------------------------
module gateway_discovery_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int               TABLE_SLOTS   = 64;
   localparam int               RANDOM_ITEMS  = 1750;
   localparam int               STALL_LIMIT   = 4000;
   localparam int               REPORT_LIMIT  = 20;
   localparam gdt_pkg::key_type KEY_POLY      = 32'hEDB88320;

   typedef struct {
      gdt_pkg::req_kind_type kind;
      logic                  discovery_on;
      logic                  from_client;
      gdt_pkg::mac_type      dst_mac;
      gdt_pkg::mac_type      src_mac;
      gdt_pkg::ip_type       src_ip;
      gdt_pkg::ip_type       dst_ip;
   } header_item_type;

   typedef struct {
      gdt_pkg::status_type status;
      gdt_pkg::index_type  slot;
      gdt_pkg::count_type  freed;
   } table_outcome_type;

   // One learned candidate, remembered so later traffic can try to commit it.
   typedef struct {
      gdt_pkg::mac_type gateway;
      gdt_pkg::mac_type client_mac;
      gdt_pkg::ip_type  client_ip;
   } candidate_type;

   logic clock = 1'b0;
   logic reset;

   gdt_req_if req_channel ();
   gdt_rsp_if rsp_channel ();
   gdt_csr_if csr_channel ();

   gateway_discovery_table #(
      .TABLE_ENTRIES(TABLE_SLOTS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_channel(req_channel),
      .rsp_channel(rsp_channel),
      .csr_channel(csr_channel)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the table and its lifetime register.
   logic              tbl_valid     [TABLE_SLOTS];
   gdt_pkg::key_type  tbl_key       [TABLE_SLOTS];
   logic              tbl_committed [TABLE_SLOTS];
   gdt_pkg::mac_type  tbl_gateway   [TABLE_SLOTS];
   gdt_pkg::mac_type  tbl_client_mac[TABLE_SLOTS];
   gdt_pkg::ip_type   tbl_client_ip [TABLE_SLOTS];
   gdt_pkg::life_type tbl_life      [TABLE_SLOTS];
   gdt_pkg::life_type lifetime_setting = gdt_pkg::LIFETIME_RESET;

   header_item_type   pending_headers[$];
   table_outcome_type expected_responses[$];

   int  items_queued       = 0;
   int  items_accepted     = 0;
   int  error_count        = 0;
   int  idle_cycles        = 0;
   int  sender_idle_pct    = 21;
   int  receiver_idle_pct  = 84;
   bit  req_accepted       = 1'b0;
   int  seen_learned       = 0;
   int  seen_committed     = 0;
   int  seen_full          = 0;
   int  seen_ticks         = 0;
   int  seen_expired       = 0;

   // CRC-32 of the MAC, fed bit by bit: first byte first, each byte LSB first.
   function automatic gdt_pkg::key_type mac_key(gdt_pkg::mac_type mac);
      gdt_pkg::key_type crc;
      logic             feedback;
      crc = '1;
      for (int n = 0; n < 48; n++) begin
         feedback = crc[0] ^ mac[8 * (5 - n / 8) + n % 8];
         crc = crc >> 1;
         if (feedback) crc = crc ^ KEY_POLY;
      end
      return ~crc;
   endfunction

   // Build a different MAC with the same key. The key is affine in the MAC,
   // so reduce random vectors until a combination maps to zero.
   function automatic gdt_pkg::mac_type key_twin(gdt_pkg::mac_type mac);
      gdt_pkg::key_type basis_key[32];
      gdt_pkg::mac_type basis_mac[32];
      logic [31:0]      have;
      gdt_pkg::key_type base;
      gdt_pkg::key_type v;
      gdt_pkg::mac_type mix;
      have = '0;
      base = mac_key('0);
      for (int n = 0; n < 256; n++) begin
         mix = gdt_pkg::mac_type'({$urandom, $urandom});
         v   = mac_key(mix) ^ base;
         for (int b = 31; b >= 0; b--) begin
            if (v[b]) begin
               if (have[b]) begin
                  v   = v ^ basis_key[b];
                  mix = mix ^ basis_mac[b];
               end else begin
                  basis_key[b] = v;
                  basis_mac[b] = mix;
                  have[b]      = 1'b1;
                  break;
               end
            end
         end
         if (v == '0 && mix != '0) return mac ^ mix;
      end
      return mac;
   endfunction

   function automatic gdt_pkg::mac_type random_mac();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         default: return gdt_pkg::mac_type'({$urandom, $urandom});
      endcase
   endfunction

   function automatic gdt_pkg::ip_type random_ip();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         default: return gdt_pkg::ip_type'($urandom);
      endcase
   endfunction

   function automatic header_item_type make_packet(logic on, logic client,
                                                   gdt_pkg::mac_type dmac,
                                                   gdt_pkg::mac_type smac,
                                                   gdt_pkg::ip_type sip,
                                                   gdt_pkg::ip_type dip);
      header_item_type it;
      it.kind         = gdt_pkg::REQ_PACKET;
      it.discovery_on = on;
      it.from_client  = client;
      it.dst_mac      = dmac;
      it.src_mac      = smac;
      it.src_ip       = sip;
      it.dst_ip       = dip;
      return it;
   endfunction

   // Ticks carry random junk in every other field; the block must ignore it.
   function automatic header_item_type make_tick();
      header_item_type it;
      it      = make_packet(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            random_mac(), random_mac(), random_ip(), random_ip());
      it.kind = gdt_pkg::REQ_TICK;
      return it;
   endfunction

   function automatic int find_entry(gdt_pkg::key_type key);
      for (int i = 0; i < TABLE_SLOTS; i++)
         if (tbl_valid[i] && tbl_key[i] == key) return i;
      return -1;
   endfunction

   // Apply one accepted item to the shadow table and queue the response it
   // must produce.
   function automatic void predict_table_response(header_item_type it);
      table_outcome_type o;
      int                slot;
      gdt_pkg::key_type  key;
      o.status = gdt_pkg::STATUS_NONE;
      o.slot   = '0;
      o.freed  = '0;
      if (it.kind == gdt_pkg::REQ_TICK) begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (tbl_valid[i]) begin
               if (tbl_life[i] != '0) tbl_life[i] = tbl_life[i] - 1'b1;
               if (tbl_life[i] == '0) begin
                  tbl_valid[i] = 1'b0;
                  o.freed      = o.freed + 1'b1;
               end
            end
         end
         o.status = gdt_pkg::STATUS_TICK;
      end else if (it.discovery_on) begin
         if (it.from_client) begin
            key = mac_key(it.dst_mac);
            if (find_entry(key) < 0) begin
               slot = -1;
               for (int i = 0; i < TABLE_SLOTS; i++) begin
                  if (!tbl_valid[i]) begin
                     slot = i;
                     break;
                  end
               end
               if (slot < 0) begin
                  o.status = gdt_pkg::STATUS_FULL;
               end else begin
                  tbl_valid[slot]      = 1'b1;
                  tbl_key[slot]        = key;
                  tbl_committed[slot]  = 1'b0;
                  tbl_gateway[slot]    = it.dst_mac;
                  tbl_client_mac[slot] = it.src_mac;
                  tbl_client_ip[slot]  = it.src_ip;
                  tbl_life[slot]       = lifetime_setting;
                  o.status             = gdt_pkg::STATUS_LEARNED;
                  o.slot               = gdt_pkg::index_type'(slot);
               end
            end
         end else begin
            slot = find_entry(mac_key(it.src_mac));
            if (slot >= 0 && !tbl_committed[slot] &&
                tbl_client_ip[slot] == it.dst_ip &&
                tbl_client_mac[slot] == it.dst_mac &&
                tbl_gateway[slot] == it.src_mac) begin
               tbl_committed[slot] = 1'b1;
               o.status            = gdt_pkg::STATUS_COMMITTED;
               o.slot              = gdt_pkg::index_type'(slot);
            end
         end
      end
      expected_responses.push_back(o);
   endfunction

   task automatic queue_header(header_item_type it);
      pending_headers.push_back(it);
      items_queued++;
   endtask

   // Hold until every queued item went in and every response came back.
   task automatic wait_until_idle();
      while (items_accepted != items_queued || expected_responses.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_lifetime(gdt_pkg::life_type value);
      wait_until_idle();
      @(negedge clock);
      csr_channel.valid <= 1'b1;
      csr_channel.data  <= value;
      do @(posedge clock); while (!csr_channel.ready);
      @(negedge clock);
      csr_channel.valid <= 1'b0;
   endtask

   // Request driver: advance to the next header only once the shown one
   // transferred, and idle between items at the current sender rate.
   always @(negedge clock) begin : drive_requests
      header_item_type shown;
      if (!reset && (!req_channel.valid || req_accepted)) begin
         if (pending_headers.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            shown = pending_headers.pop_front();
            req_channel.valid            <= 1'b1;
            req_channel.req_type         <= shown.kind;
            req_channel.discovery_on     <= shown.discovery_on;
            req_channel.from_client_link <= shown.from_client;
            req_channel.dst_mac          <= shown.dst_mac;
            req_channel.src_mac          <= shown.src_mac;
            req_channel.src_ip           <= shown.src_ip;
            req_channel.dst_ip           <= shown.dst_ip;
         end else begin
            req_channel.valid <= 1'b0;
         end
      end
   end

   // Response backpressure at the current receiver rate.
   always @(negedge clock) begin
      rsp_channel.ready <= !reset && ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   // Monitor: predict on every request transfer, check every response
   // transfer, track register writes and watch for a hung block.
   always @(posedge clock) begin : watch_channels
      header_item_type   got;
      table_outcome_type want;
      logic              moved;
      moved        = 1'b0;
      req_accepted = 1'b0;
      if (!reset) begin
         if (csr_channel.valid && csr_channel.ready) begin
            lifetime_setting = csr_channel.data;
            moved            = 1'b1;
         end
         if (req_channel.valid && req_channel.ready) begin
            got.kind         = gdt_pkg::req_kind_type'(req_channel.req_type);
            got.discovery_on = req_channel.discovery_on;
            got.from_client  = req_channel.from_client_link;
            got.dst_mac      = req_channel.dst_mac;
            got.src_mac      = req_channel.src_mac;
            got.src_ip       = req_channel.src_ip;
            got.dst_ip       = req_channel.dst_ip;
            predict_table_response(got);
            items_accepted++;
            req_accepted = 1'b1;
            moved        = 1'b1;
         end
         if (rsp_channel.valid && rsp_channel.ready) begin
            moved = 1'b1;
            if (expected_responses.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: response with no item pending: status %0d index %0d freed %0d",
                           $time, rsp_channel.status, rsp_channel.entry_index,
                           rsp_channel.expired_count);
            end else begin
               want = expected_responses.pop_front();
               if (rsp_channel.status !== want.status) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display("%0t: status expected %0d actual %0d", $time,
                              want.status, rsp_channel.status);
               end
               if (rsp_channel.entry_index !== want.slot) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display("%0t: entry_index expected %0d actual %0d", $time,
                              want.slot, rsp_channel.entry_index);
               end
               if (rsp_channel.expired_count !== want.freed) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display("%0t: expired_count expected %0d actual %0d", $time,
                              want.freed, rsp_channel.expired_count);
               end
            end
            case (rsp_channel.status)
               gdt_pkg::STATUS_LEARNED:   seen_learned++;
               gdt_pkg::STATUS_COMMITTED: seen_committed++;
               gdt_pkg::STATUS_FULL:      seen_full++;
               gdt_pkg::STATUS_TICK: begin
                  seen_ticks++;
                  seen_expired += rsp_channel.expired_count;
               end
               default: ;
            endcase
         end
         if (moved) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("gateway_discovery_table verification failed");
            $finish;
         end
      end
   end

   initial begin
      header_item_type   it;
      candidate_type     cand;
      candidate_type     learned_pool[$];
      gdt_pkg::life_type setting;
      int                traffic_count;
      int                pick;

      // Drive every input to a known value before the first edge.
      reset                        = 1'b1;
      req_channel.valid            = 1'b0;
      req_channel.req_type         = gdt_pkg::REQ_PACKET;
      req_channel.discovery_on     = 1'b0;
      req_channel.from_client_link = 1'b0;
      req_channel.dst_mac          = '0;
      req_channel.src_mac          = '0;
      req_channel.src_ip           = '0;
      req_channel.dst_ip           = '0;
      rsp_channel.ready            = 1'b0;
      csr_channel.valid            = 1'b0;
      csr_channel.data             = '0;
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed pass under the reset lifetime. Slot 0 learns the all-zero
      // gateway, slot 1 the all-ones one.
      queue_header(make_tick());
      queue_header(make_packet(1'b1, 1'b1, '0, '1, '1, '0));
      queue_header(make_packet(1'b1, 1'b1, '1, '0, '0, '1));
      // known key on the client link, then a different MAC with the same key
      queue_header(make_packet(1'b1, 1'b1, '0, random_mac(), random_ip(), random_ip()));
      queue_header(make_packet(1'b1, 1'b1, key_twin('1), random_mac(), random_ip(),
                               random_ip()));
      // commit slot 0, then try again once it is committed
      queue_header(make_packet(1'b1, 1'b0, '1, '0, random_ip(), '1));
      queue_header(make_packet(1'b1, 1'b0, '1, '0, random_ip(), '1));
      // broken commits of slot 1: client IP, client MAC, gateway MAC differ
      queue_header(make_packet(1'b1, 1'b0, '0, '1, random_ip(), 32'd1));
      queue_header(make_packet(1'b1, 1'b0, 48'd1, '1, random_ip(), '0));
      queue_header(make_packet(1'b1, 1'b0, '0, key_twin('1), random_ip(), '0));
      // absent key on the server link
      queue_header(make_packet(1'b1, 1'b0, '0, 48'h0123_4567_89AB, random_ip(), '0));
      // discovery off blocks both a learn and a good commit
      queue_header(make_packet(1'b0, 1'b1, random_mac(), random_mac(), random_ip(),
                               random_ip()));
      queue_header(make_packet(1'b0, 1'b0, '0, '1, random_ip(), '0));
      queue_header(make_packet(1'b1, 1'b0, '0, '1, random_ip(), '0));
      queue_header(make_tick());

      // An entry learned with a zero lifetime goes at the next tick.
      write_lifetime('0);
      queue_header(make_packet(1'b1, 1'b1, 48'h0200_0000_0001, random_mac(), random_ip(),
                               random_ip()));
      queue_header(make_tick());

      // Random traffic: mostly learn/commit sequences, plus broken commits,
      // key collisions, ticks and noise. Two lifetime settings per idle mix.
      traffic_count = 0;
      for (int seg = 0; seg < 6; seg++) begin
         case (seg)
            0, 4:    setting = '1;
            1:       setting = 8'd1;
            2:       setting = gdt_pkg::life_type'($urandom_range(2, 10));
            3:       setting = gdt_pkg::life_type'($urandom_range(1, 255));
            default: setting = gdt_pkg::life_type'($urandom_range(1, 4));
         endcase
         write_lifetime(setting);
         case (seg / 2)
            0: begin
               sender_idle_pct   = 21;
               receiver_idle_pct = 84;
            end
            1: begin
               sender_idle_pct   = 84;
               receiver_idle_pct = 21;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         while (traffic_count < RANDOM_ITEMS * (seg + 1) / 6) begin
            pick = $urandom_range(0, 99);
            if (pick < 30 || learned_pool.size() == 0) begin
               cand.gateway    = random_mac();
               cand.client_mac = random_mac();
               cand.client_ip  = random_ip();
               queue_header(make_packet(1'b1, 1'b1, cand.gateway, cand.client_mac,
                                        cand.client_ip, random_ip()));
               learned_pool.push_back(cand);
               if (learned_pool.size() > 80) void'(learned_pool.pop_front());
            end else begin
               cand = learned_pool[$urandom_range(0, learned_pool.size() - 1)];
               it   = make_packet(1'b1, 1'b0, cand.client_mac, cand.gateway, random_ip(),
                                  cand.client_ip);
               if (pick < 55) begin
                  queue_header(it);
               end else if (pick < 65) begin
                  // spoil one thing about an otherwise good commit
                  case ($urandom_range(0, 3))
                     0: it.dst_ip  = it.dst_ip ^
                                     (gdt_pkg::ip_type'(1) << $urandom_range(0, 31));
                     1: it.dst_mac = it.dst_mac ^
                                     (gdt_pkg::mac_type'(1) << $urandom_range(0, 47));
                     2: it.src_mac = key_twin(cand.gateway);
                     default: it.src_mac = it.src_mac ^
                                     (gdt_pkg::mac_type'(1) << $urandom_range(0, 47));
                  endcase
                  queue_header(it);
               end else if (pick < 73) begin
                  it.from_client = 1'b1;
                  it.dst_mac     = $urandom_range(0, 1) ? cand.gateway : key_twin(cand.gateway);
                  it.src_mac     = random_mac();
                  queue_header(it);
               end else if (pick < 81) begin
                  queue_header(make_tick());
               end else if (pick < 89) begin
                  it.discovery_on = 1'b0;
                  it.from_client  = 1'($urandom_range(0, 1));
                  queue_header(it);
               end else begin
                  it      = make_packet(1'b1, 1'($urandom_range(0, 1)), random_mac(),
                                        random_mac(), random_ip(), random_ip());
                  it.kind = gdt_pkg::req_kind_type'($urandom_range(0, 1));
                  queue_header(it);
               end
            end
            traffic_count++;
         end
      end

      wait_until_idle();
      repeat (TABLE_SLOTS + 16) @(posedge clock);

      if (expected_responses.size() != 0) begin
         error_count++;
         $display("%0t: %0d responses never arrived", $time, expected_responses.size());
      end
      $display("Ran %0d items: %0d learned, %0d committed, %0d dropped on a full table",
               items_accepted, seen_learned, seen_committed, seen_full);
      $display("%0d ageing ticks freed %0d entries over lifetimes 0, 1, 60, 255 and random",
               seen_ticks, seen_expired);
      if (error_count == 0) begin
         $display("gateway_discovery_table verification clean");
      end else begin
         $display("gateway_discovery_table verification failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/gdt_pkg.sv
hw/rtl/gdt_channels.sv
hw/rtl/gateway_discovery_table.sv
tb/sv/gateway_discovery_table_tb.sv
